>>> sv/aes128_pkg.sv
// Package with AES-128 key expansion constants and the S-box function.
package aes128_pkg;

  localparam int unsigned KeyWords      = 4;
  localparam int unsigned ScheduleWords = 4 * (10 + 1);
  localparam int unsigned IndexWidth    = 6;
  localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(ScheduleWords - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tbl[a];
  endfunction

  // Next round constant: doubling in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

>>> sv/aes128_key_expansion_unit.sv
// AES-128 key expansion unit: one key in, 44 schedule words out.
//
// Input channel: key_valid / key_stall with key_high and key_low. One key is
// taken when key_valid is high and key_stall is low; key_stall is high while
// a schedule is being emitted, so the block works on one key at a time.
// Output channel: out_valid / out_stall with round_key_word, word_index and
// last_word. Each word handshake moves one schedule word, in order 0 to 43,
// and last_word marks word 43.
// Word 0 appears the cycle after the key is taken. Afterwards one word leaves
// per cycle without stall, and after word 43 the block returns to idle before
// it takes the next key. The rate is set by the four-word window, a shift
// register of 32-bit words advanced one word per output handshake; each new
// word is built from the oldest and newest words with one S-box layer of four
// table lookups, so the logic per cycle stays one word wide.
// When the receiver stalls, the output word and the window hold unchanged.
// Reset (rst, synchronous) returns the block to idle with no word pending.
module aes128_key_expansion_unit
  import aes128_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  key_valid,
  output logic                  key_stall,
  input  logic [63:0]           key_high,
  input  logic [63:0]           key_low,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           round_key_word,
  output logic [IndexWidth-1:0] word_index,
  output logic                  last_word
);

  state_t                state;
  logic [31:0]           win [KeyWords];  // win[0] is the word on the output
  logic [IndexWidth-1:0] idx;
  logic [7:0]            rcon;
  logic [31:0]           t;
  logic [31:0]           new_word;
  logic                  take_key;
  logic                  move;

  assign key_stall      = (state != ST_IDLE);
  assign take_key       = key_valid && (state == ST_IDLE);
  assign out_valid      = (state == ST_RUN);
  assign move           = out_valid && !out_stall;
  assign round_key_word = win[0];
  assign word_index     = idx;
  assign last_word      = (idx == LastIndex);

  // The word after win[3] has index idx+4; it is transformed when that is a
  // multiple of four, which is when idx itself is.
  always_comb begin
    t = win[3];
    if (idx[1:0] == 2'b00) begin
      t = {sbox(win[3][23:16]) ^ rcon, sbox(win[3][15:8]),
           sbox(win[3][7:0]), sbox(win[3][31:24])};
    end
    new_word = win[0] ^ t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (take_key) begin
      state <= ST_RUN;
    end else if (move && last_word) begin
      state <= ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (take_key) begin
      win[0] <= key_high[63:32];
      win[1] <= key_high[31:0];
      win[2] <= key_low[63:32];
      win[3] <= key_low[31:0];
      idx    <= '0;
      rcon   <= 8'h01;
    end else if (move) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= win[3];
      win[3] <= new_word;
      idx    <= idx + 1'b1;
      if (idx[1:0] == 2'b00) begin
        rcon <= xtime(rcon);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (idx <= LastIndex)) else $error("word index out of range");
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    take_key |=> (out_valid && idx == '0)) else $error("schedule not started at 0");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(idx) && $stable(round_key_word)))
    else $error("stalled word changed");
  a_end: assert property (@(posedge clk) disable iff (rst)
    (move && last_word) |=> !out_valid) else $error("word after last");
`endif

endmodule

>>> tb/aes128_key_expansion_unit_tb.sv
// Self-checking testbench for the AES-128 key expansion unit.
module aes128_key_expansion_unit_tb;
  import aes128_pkg::*;

  // The block takes one cipher key and emits the 44-word AES-128 schedule, one word
  // per output handshake. A predictor in this file expands each accepted key into its
  // 44 expected words. A checker process compares every accepted output word against
  // the oldest pending expectation.

  logic                  clk;
  logic                  rst;
  logic                  key_valid;
  logic                  key_stall;
  logic [63:0]           key_high;
  logic [63:0]           key_low;
  logic                  out_valid;
  logic                  out_stall;
  logic [31:0]           round_key_word;
  logic [IndexWidth-1:0] word_index;
  logic                  last_word;

  typedef struct packed {
    logic [31:0]           rk;
    logic [IndexWidth-1:0] idx;
    logic                  last;
  } sched_word_t;

  sched_word_t pending_words[$];
  int          error_count;
  int          keys_sent;
  int          words_checked;
  int          idle_cycles;
  bit          stall_enable;
  int          stall_mode;

  localparam int WatchdogLimit = 2000;

  aes128_key_expansion_unit uut (
    .clk(clk), .rst(rst),
    .key_valid(key_valid), .key_stall(key_stall),
    .key_high(key_high), .key_low(key_low),
    .out_valid(out_valid), .out_stall(out_stall),
    .round_key_word(round_key_word), .word_index(word_index), .last_word(last_word)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // The test keeps its own S-box and round constant tables. They are not taken from the package.
  logic [7:0] sub_table [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  logic [7:0] rcon_table [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                  8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  // This task expands one key and queues its 44 expected words. Every fourth word
  // passes the previous word through a byte rotate, the S-box and the round constant.
  task automatic expand_key(input logic [63:0] hi, input logic [63:0] lo);
    logic [31:0] w [ScheduleWords];
    logic [31:0] t;
    sched_word_t e;
    w[0] = hi[63:32]; w[1] = hi[31:0]; w[2] = lo[63:32]; w[3] = lo[31:0];
    for (int i = KeyWords; i < ScheduleWords; i++) begin
      t = w[i-1];
      if (i % KeyWords == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sub_table[t[31:24]], sub_table[t[23:16]], sub_table[t[15:8]], sub_table[t[7:0]]};
        t[31:24] ^= rcon_table[i/KeyWords - 1];
      end
      w[i] = w[i-KeyWords] ^ t;
    end
    for (int i = 0; i < ScheduleWords; i++) begin
      e.rk = w[i];
      e.idx = IndexWidth'(i);
      e.last = (i == ScheduleWords - 1);
      pending_words.push_back(e);
    end
  endtask

  // This task offers one key at the falling edge and holds it until the block accepts it.
  // It then drops valid at the falling edge and drives random data on the key lines.
  task automatic send_key(input logic [63:0] hi, input logic [63:0] lo);
    key_high  = hi;
    key_low   = lo;
    key_valid = 1'b1;
    do @(posedge clk); while (key_stall);
    expand_key(hi, lo);
    keys_sent++;
    @(negedge clk);
    key_valid = 1'b0;
    key_high  = {$urandom, $urandom};
    key_low   = {$urandom, $urandom};
  endtask

  task automatic idle_gap(input int max_gap);
    repeat ($urandom_range(max_gap, 0)) @(negedge clk);
  endtask

  // The known-answer key from FIPS-197 appendix A.1.
  task automatic test_known_answer();
    send_key(64'h2b7e1516_28aed2a6, 64'habf71588_09cf4f3c);
  endtask

  // These keys cover the field extremes: all zeros, all ones, alternating bit patterns,
  // a single bit at each end, and a walking one through both halves.
  task automatic test_extreme_keys();
    send_key('0, '0);
    send_key('1, '1);
    send_key(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_key(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_key(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    for (int b = 0; b < 128; b += 13) begin
      send_key(b >= 64 ? 64'd1 << (b - 64) : '0, b < 64 ? 64'd1 << b : '0);
      idle_gap(2);
    end
  endtask

  // Random keys are sent in bursts, with random gaps between the bursts.
  task automatic test_random_keys(input int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(6, 1);
      for (int k = 0; k < burst && left > 0; k++, left--)
        send_key({$urandom, $urandom}, {$urandom, $urandom});
      idle_gap(30);
    end
  endtask

  // Receiver stall: the pattern changes mode on its own, as either no stall,
  // light random stall, heavy random stall or long stall runs.
  always @(negedge clk) begin
    if (!stall_enable) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(99, 0) == 0) stall_mode = $urandom_range(3, 0);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3, 0) == 0);
        2: out_stall <= ($urandom_range(3, 0) != 0);
        default: out_stall <= ($urandom_range(15, 0) < 12) ? out_stall : ~out_stall;
      endcase
    end
  end

  // The checker compares every accepted word with the oldest expectation, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h idx %0d last %b", $time,
                 round_key_word, word_index, last_word);
        error_count++;
      end else begin
        sched_word_t e;
        e = pending_words.pop_front();
        if (round_key_word !== e.rk) begin
          $display("%0t: round_key_word idx %0d expected %h actual %h", $time,
                   e.idx, e.rk, round_key_word);
          error_count++;
        end
        if (word_index !== e.idx) begin
          $display("%0t: word_index expected %0d actual %0d", $time, e.idx, word_index);
          error_count++;
        end
        if (last_word !== e.last) begin
          $display("%0t: last_word idx %0d expected %b actual %b", $time,
                   e.idx, e.last, last_word);
          error_count++;
        end
        words_checked++;
      end
    end
  end

  // The watchdog ends the run if no word is accepted on either channel for too long.
  always @(posedge clk) begin
    if (rst || (key_valid && !key_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else if (key_valid || pending_words.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d words pending", $time, pending_words.size());
      $display("aes128_key_expansion_unit regression: fail");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    key_valid    = 1'b0;
    key_high     = '0;
    key_low      = '0;
    out_stall    = 1'b0;
    stall_enable = 1'b0;
    stall_mode   = 0;
    error_count  = 0;
    keys_sent    = 0;
    words_checked = 0;
    idle_cycles  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_known_answer();
    stall_enable = 1'b1;
    test_extreme_keys();
    test_random_keys(114);

    wait (pending_words.size() == 0);
    repeat (50) @(posedge clk);
    $display("Covered %0d keys (known answer, extremes, walking one, random), %0d words checked",
             keys_sent, words_checked);
    $display("Receiver stall ran in several modes, and keys were sent in bursts with random gaps.");
    if (error_count == 0 && pending_words.size() == 0)
      $display("aes128_key_expansion_unit regression: pass");
    else
      $display("aes128_key_expansion_unit regression: fail");
    $finish;
  end

endmodule

>>> sim.f
sv/aes128_pkg.sv
sv/aes128_key_expansion_unit.sv
tb/aes128_key_expansion_unit_tb.sv
